// File: rtl/core/gcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_pkg
// shared widths and constants for the gcd / lcm unit
// ----------------------------------------------------------------------------
package gcl_pkg;

    localparam int WIDTH  = 32;                 // operand width
    localparam int RES_W  = WIDTH - 1;          // result width
    localparam int ALU_W  = WIDTH + 2;          // shared adder width
    localparam int CNT_W  = $clog2(WIDTH);      // step counter width

    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

    localparam logic CMD_GCD = 1'b0;
    localparam logic CMD_LCM = 1'b1;

endpackage

// File: rtl/core/gcl_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_alu
// shared add / subtract unit for division and multiplication steps
// ----------------------------------------------------------------------------
module gcl_alu
    import gcl_pkg::*;
(
    input  logic [ALU_W-1:0] op_a,
    input  logic [ALU_W-1:0] op_b,
    input  logic             sub,
    output logic [ALU_W-1:0] sum
);

    logic [ALU_W-1:0] op_b_eff;

    // two's complement subtract by inverting and carrying in
    assign op_b_eff = sub ? ~op_b : op_b;
    assign sum      = op_a + op_b_eff + {{(ALU_W-1){1'b0}}, sub};

endmodule

// File: rtl/core/gcd_lcm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// iterative gcd / lcm of two signed operands with saturation
// ----------------------------------------------------------------------------
// usage
//   request channel: cmd_valid / cmd_stall with command, operand_a, operand_b
//   (command 0 = gcd, 1 = lcm). a request is taken when cmd_valid is high and
//   cmd_stall is low; cmd_stall stays high from the taking edge until the
//   result has moved into the output register.
//   result channel: res_valid / res_stall with result_value and overflow.
//   overflow set means the true result did not fit and result_value is the
//   saturated maximum.
// sequence, with k Euclid remainder steps (k is at most about 46 at 32 bits)
//   gcd : prep, then k remainder steps each ending in a swap, then finish
//   lcm : the same plus a quotient division and a multiply before finish;
//   a zero operand goes from prep straight to finish. one request at a time;
//   each remainder is a WIDTH-step restoring division on the shared adder,
//   the lcm adds one division and one shift-add multiply. the next request
//   can be taken in the cycle after the result loads, at the earliest
// reset clears the sequencer and the output valid; no state survives a request
// a stalled receiver holds the result in the output register; a new request
// can be taken meanwhile and waits in its final step until the register frees
// ----------------------------------------------------------------------------
module gcd_lcm_unit
    import gcl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  logic             command,
    input  logic [WIDTH-1:0] operand_a,
    input  logic [WIDTH-1:0] operand_b,

    output logic             res_valid,
    input  logic             res_stall,
    output logic [RES_W-1:0] result_value,
    output logic             overflow
);

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PREP   = 7'b0000010,
        ST_EUCLID = 7'b0000100,
        ST_SWAP   = 7'b0001000,
        ST_QUOT   = 7'b0010000,
        ST_MUL    = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // request registers
    logic             cmd_reg;
    logic [WIDTH-1:0] a_mag_reg;
    logic [WIDTH-1:0] b_mag_reg;

    // division / multiply working registers
    logic [WIDTH-1:0] q_reg;        // dividend shifting to quotient, or multiplier
    logic [WIDTH-1:0] r_reg;        // partial remainder
    logic [WIDTH-1:0] d_reg;        // divisor, holds the gcd at the end of euclid
    logic [WIDTH-1:0] acc_reg;      // product accumulator
    logic             sticky_reg;   // product has exceeded the range
    logic [CNT_W-1:0] cnt_reg;

    // final value before saturation
    logic [WIDTH-1:0] fin_val_reg;
    logic             fin_ovf_reg;

    // output register
    logic             res_valid_reg;
    logic [RES_W-1:0] result_value_reg;
    logic             overflow_reg;

    logic             take_req;
    logic             load_out;
    logic             div_step;
    logic [WIDTH:0]   shifted;
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic             alu_sub;
    logic [ALU_W-1:0] alu_sum;
    logic             div_neg;
    logic             mul_over;
    logic             sticky_next;
    logic             last_step;
    logic [WIDTH-1:0] mag_a;
    logic [WIDTH-1:0] mag_b;

    assign take_req  = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign load_out  = (state_reg == ST_FINISH) && (!res_valid_reg || !res_stall);
    assign div_step  = (state_reg == ST_EUCLID) || (state_reg == ST_QUOT);
    assign last_step = (cnt_reg == '0);

    // absolute values, the most negative input stays exact as 2^(WIDTH-1)
    assign mag_a = operand_a[WIDTH-1] ? (~operand_a + 1'b1) : operand_a;
    assign mag_b = operand_b[WIDTH-1] ? (~operand_b + 1'b1) : operand_b;

    // shared adder operand selection
    assign shifted = {r_reg, q_reg[WIDTH-1]};

    always_comb
    begin
        if (div_step)
        begin
            // trial subtract of the divisor from the shifted remainder
            alu_a   = {1'b0, shifted};
            alu_b   = {2'b00, d_reg};
            alu_sub = 1'b1;
        end
        else
        begin
            // msb-first shift-add: acc * 2 plus multiplicand when the bit is set
            alu_a   = {1'b0, acc_reg, 1'b0};
            alu_b   = q_reg[WIDTH-1] ? {2'b00, b_mag_reg} : '0;
            alu_sub = 1'b0;
        end
    end

    gcl_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum)
    );

    assign div_neg     = alu_sum[ALU_W-1];
    // any bit at or above the top operand bit means the product left the range
    assign mul_over    = (alu_sum[ALU_W-1:WIDTH-1] != '0);
    assign sticky_next = sticky_reg || mul_over;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_req)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if ((a_mag_reg == '0) || (b_mag_reg == '0))
                    state_next = ST_FINISH;
                else
                    state_next = ST_EUCLID;
            end
            ST_EUCLID:
            begin
                if (last_step)
                    state_next = ST_SWAP;
            end
            ST_SWAP:
            begin
                if (r_reg != '0)
                    state_next = ST_EUCLID;
                else if (cmd_reg == CMD_LCM)
                    state_next = ST_QUOT;
                else
                    state_next = ST_FINISH;
            end
            ST_QUOT:
            begin
                if (last_step)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (last_step)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            cmd_reg   <= command;
            a_mag_reg <= mag_a;
            b_mag_reg <= mag_b;
        end

        unique case (state_reg)
            ST_PREP:
            begin
                if ((a_mag_reg == '0) || (b_mag_reg == '0))
                begin
                    if (cmd_reg == CMD_LCM)
                    begin
                        fin_val_reg <= '0;
                        fin_ovf_reg <= 1'b0;
                    end
                    else
                    begin
                        // gcd with a zero operand is the other magnitude
                        fin_val_reg <= a_mag_reg | b_mag_reg;
                        fin_ovf_reg <= a_mag_reg[WIDTH-1] | b_mag_reg[WIDTH-1];
                    end
                end
                q_reg   <= a_mag_reg;
                r_reg   <= '0;
                d_reg   <= b_mag_reg;
                cnt_reg <= CNT_W'(WIDTH - 1);
            end
            ST_EUCLID, ST_QUOT:
            begin
                if (div_neg)
                begin
                    r_reg <= shifted[WIDTH-1:0];
                    q_reg <= {q_reg[WIDTH-2:0], 1'b0};
                end
                else
                begin
                    r_reg <= alu_sum[WIDTH-1:0];
                    q_reg <= {q_reg[WIDTH-2:0], 1'b1};
                end
                if (last_step && (state_reg == ST_QUOT))
                begin
                    acc_reg    <= '0;
                    sticky_reg <= 1'b0;
                    cnt_reg    <= CNT_W'(WIDTH - 1);
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            ST_SWAP:
            begin
                if (r_reg != '0)
                begin
                    // next remainder step: old divisor by the remainder
                    q_reg <= d_reg;
                    d_reg <= r_reg;
                end
                else
                begin
                    // d_reg holds the gcd; lcm divides |a| by it
                    q_reg       <= a_mag_reg;
                    fin_val_reg <= d_reg;
                    fin_ovf_reg <= d_reg[WIDTH-1];
                end
                r_reg   <= '0;
                cnt_reg <= CNT_W'(WIDTH - 1);
            end
            ST_MUL:
            begin
                q_reg      <= {q_reg[WIDTH-2:0], 1'b0};
                sticky_reg <= sticky_next;
                cnt_reg    <= cnt_reg - 1'b1;
                if (!sticky_next)
                    acc_reg <= alu_sum[WIDTH-1:0];
                if (last_step)
                begin
                    fin_val_reg <= sticky_next ? '0 : alu_sum[WIDTH-1:0];
                    fin_ovf_reg <= sticky_next;
                end
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            result_value_reg <= fin_ovf_reg ? RES_MAX : fin_val_reg[RES_W-1:0];
            overflow_reg     <= fin_ovf_reg;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (load_out)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    assign res_valid    = res_valid_reg;
    assign result_value = result_value_reg;
    assign overflow     = overflow_reg;

    // a flagged result always carries the saturated maximum
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && overflow) |-> (result_value == RES_MAX))
        else $error("overflow without saturated result");

    // a taken request blocks the channel on the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("request channel open while busy");

    // euclid and quotient steps never divide by zero
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EUCLID) || (state_reg == ST_QUOT)) |-> (d_reg != '0))
        else $error("division by zero in iteration");

    // a new result appears only out of the final step
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result valid without a finished request");

endmodule

// File: verif/gcd_lcm_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_lcm_unit_tb
// self-checking bench for the iterative gcd / lcm unit: a short directed
// set of corner requests, then about fourteen hundred random gcd and lcm
// requests. each taken request is predicted by a scoreboard object and every
// result is checked in order against it, with random idling on both sides
// ----------------------------------------------------------------------------
module gcd_lcm_unit_tb
    import gcl_pkg::*;
;

    // run shape
    localparam int          N_RANDOM    = 1380;     // random requests after the directed set
    localparam int          HOLD_AT     = 300;      // receiver long hold-off starts here
    localparam int          HOLD_ITEMS  = 12;       // short requests pushed during the hold-off
    localparam int          DRAIN_AT    = 700;      // sender waits for an empty scoreboard here
    localparam int          QUIET_FROM  = N_RANDOM - 150;
    localparam int unsigned LONG_HOLD   = 1500;     // cycles of receiver hold-off
    localparam int unsigned TAIL_CYCLES = 2000;     // settle time after the last result
    // room for about 1400 worst-case requests plus idling, taken about three
    // times over
    localparam int unsigned CYCLE_LIMIT = 8_000_000;

    localparam logic [WIDTH-1:0] OP_MIN = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] OP_MAX = {1'b0, {(WIDTH-1){1'b1}}};

    // one predicted answer, with the request kept for the mismatch report
    typedef struct {
        logic             cmd;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [RES_W-1:0] value;
        logic             sat;
    } answer_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts gcd / lcm for each taken request, holds the answers
    // in order and compares them with what comes out of the unit
    // ------------------------------------------------------------------------
    class gcd_lcm_book;
        answer_t     answers_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned gcd_taken;
        int unsigned lcm_taken;
        int unsigned saturated;

        function new();
            mismatches = 0;
            checked    = 0;
            gcd_taken  = 0;
            lcm_taken  = 0;
            saturated  = 0;
        endfunction

        // absolute value; the most negative input comes out as 2^(WIDTH-1)
        function logic [WIDTH-1:0] magnitude(input logic [WIDTH-1:0] v);
            return v[WIDTH-1] ? (~v + 1'b1) : v;
        endfunction

        // remainder loop; a zero on either side returns the other operand
        function logic [WIDTH-1:0] euclid(input logic [WIDTH-1:0] x,
                                          input logic [WIDTH-1:0] y);
            logic [WIDTH-1:0] t;
            while (y != '0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function void note_request(input logic cmd, input logic [WIDTH-1:0] a,
                                   input logic [WIDTH-1:0] b);
            answer_t            ans;
            logic [WIDTH-1:0]   ma;
            logic [WIDTH-1:0]   mb;
            logic [WIDTH-1:0]   g;
            logic [2*WIDTH-1:0] prod;
            ma        = magnitude(a);
            mb        = magnitude(b);
            ans.cmd   = cmd;
            ans.a     = a;
            ans.b     = b;
            ans.sat   = 1'b0;
            ans.value = '0;
            if (cmd == CMD_GCD)
            begin
                gcd_taken++;
                g = euclid(ma, mb);
                if (g > RES_MAX)
                    ans.sat = 1'b1;
                else
                    ans.value = g[RES_W-1:0];
            end
            else
            begin
                lcm_taken++;
                if (ma != '0 && mb != '0)
                begin
                    g    = euclid(ma, mb);
                    // double width product, cannot wrap
                    prod = {{WIDTH{1'b0}}, ma / g} * {{WIDTH{1'b0}}, mb};
                    if (prod > RES_MAX)
                        ans.sat = 1'b1;
                    else
                        ans.value = prod[RES_W-1:0];
                end
            end
            if (ans.sat)
            begin
                ans.value = RES_MAX;
                saturated++;
            end
            answers_q.push_back(ans);
        endfunction

        function void check_result(input logic [RES_W-1:0] got_value, input logic got_sat);
            answer_t want;
            if (answers_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("mismatch: result %0d overflow %0b with no request pending",
                             got_value, got_sat);
                mismatches++;
                return;
            end
            want = answers_q.pop_front();
            checked++;
            if (got_value !== want.value || got_sat !== want.sat)
            begin
                if (mismatches < 10)
                    $display({"mismatch: %s(%0d, %0d) expected %0d overflow %0b,",
                              " got %0d overflow %0b"},
                             (want.cmd == CMD_LCM) ? "lcm" : "gcd",
                             $signed(want.a), $signed(want.b),
                             want.value, want.sat, got_value, got_sat);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return answers_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and the unit
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n;

    // every input known from time zero
    logic             cmd_valid = 1'b0;
    logic             cmd_stall;
    logic             command   = CMD_GCD;
    logic [WIDTH-1:0] operand_a = '0;
    logic [WIDTH-1:0] operand_b = '0;

    logic             res_valid;
    logic             res_stall = 1'b0;
    logic [RES_W-1:0] result_value;
    logic             overflow;

    // flags shared between the sender and the receiver process, and the cycle count
    bit               long_hold_req = 1'b0;
    bit               quiet_tail    = 1'b0;
    int unsigned      cycle_count   = 0;

    gcd_lcm_book      book;

    gcd_lcm_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .result_value (result_value),
        .overflow     (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the unit hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, book.pending());
            $display("gcd_lcm_unit_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // present one request and hold it until the unit takes it; on return we
    // sit in the time step of the taking edge, so the caller may either
    // present the next request straight away or drop valid
    task automatic offer_request(input logic cmd, input logic [WIDTH-1:0] a,
                                 input logic [WIDTH-1:0] b);
        cmd_valid <= 1'b1;
        command   <= cmd;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        book.note_request(cmd, a, b);
    endtask

    // small or mid-size operands keep the remainder loop short; full width
    // ones make up half the picks, often enough to toggle every bit
    function automatic logic [WIDTH-1:0] pick_operand(input bit tame);
        logic [WIDTH-1:0] v;
        int unsigned      kind;
        kind = tame ? 1 : $urandom_range(0, 9);
        case (kind)
            0: v = '0;
            1: v = $urandom_range(0, 255);
            2: v = $urandom_range(0, 4095);
            3: v = $urandom_range(0, 65535);
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       v = OP_MIN;
                    1:       v = OP_MAX;
                    2:       v = '1;
                    default: v = 1;
                endcase
            end
            default: v = $urandom;
        endcase
        if (kind >= 1 && kind <= 3 && $urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // result side: check whatever is taken, then pick next cycle's stall
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
                book.check_result(result_value, overflow);
            if (long_hold_req)
            begin
                // long hold-off, so a finished result sits in the output
                // register and the next request backs up behind it
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            else if (hold_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 4);
            if (hold_left != 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic             cmd;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        int unsigned      k;
        bit               tame;

        book  = new();
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: zeros, the most negative operand, sign mixes,
        // lcm right at and just past the top of the range, and the longest
        // remainder chain (consecutive fibonacci numbers)
        offer_request(CMD_GCD, 0, 0);
        offer_request(CMD_LCM, 0, 0);
        offer_request(CMD_GCD, OP_MIN, 0);
        offer_request(CMD_GCD, 0, OP_MIN);
        offer_request(CMD_GCD, OP_MIN, OP_MIN);
        offer_request(CMD_GCD, OP_MIN, 6);
        offer_request(CMD_GCD, OP_MIN, OP_MAX);
        offer_request(CMD_LCM, OP_MIN, 1);
        offer_request(CMD_LCM, OP_MIN, 0);
        offer_request(CMD_GCD, OP_MAX, OP_MAX);
        offer_request(CMD_GCD, OP_MAX, -1);
        offer_request(CMD_LCM, OP_MAX, 1);
        offer_request(CMD_LCM, -1, OP_MAX);
        offer_request(CMD_GCD, 0, -7);
        offer_request(CMD_LCM, 0, 5);
        offer_request(CMD_LCM, 5, 0);
        offer_request(CMD_GCD, -12, -18);
        offer_request(CMD_LCM, -12, 18);
        offer_request(CMD_LCM, 65536, 32768);
        offer_request(CMD_LCM, 65536, 65537);
        offer_request(CMD_LCM, 46340, 46341);
        offer_request(CMD_LCM, 46341, 46342);
        offer_request(CMD_GCD, 1836311903, 1134903170);
        offer_request(CMD_LCM, 1836311903, -1134903170);
        offer_request(CMD_GCD, -1, -1);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == HOLD_AT)
                long_hold_req = 1'b1;
            if (i == DRAIN_AT)
            begin
                // let the unit run dry before going on
                cmd_valid <= 1'b0;
                while (book.pending() != 0)
                    @(posedge clk);
            end
            if (i == QUIET_FROM)
                quiet_tail = 1'b1;

            tame = (i >= HOLD_AT && i < HOLD_AT + HOLD_ITEMS);
            cmd  = $urandom_range(0, 1) ? CMD_LCM : CMD_GCD;
            a    = pick_operand(tame);
            b    = pick_operand(tame);
            // shared factor now and then so gcds other than one turn up
            if (!tame && $urandom_range(0, 3) == 0)
            begin
                k = $urandom_range(2, 5000);
                a = a * k;
                b = b * k;
            end
            offer_request(cmd, a, b);

            // sender idling in short bursts, none while the receiver holds
            // off or in the quiet tail
            if (!quiet_tail && !tame && $urandom_range(0, 3) == 0)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
        cmd_valid <= 1'b0;

        while (book.pending() != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d gcd and %0d lcm requests, %0d of them saturating",
                 book.gcd_taken, book.lcm_taken, book.saturated);
        $display("%0d results checked, %0d mismatches, %0d never returned",
                 book.checked, book.mismatches, book.pending());
        if (book.mismatches == 0 && book.pending() == 0)
            $display("gcd_lcm_unit_tb: clean");
        else
            $display("gcd_lcm_unit_tb: errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/gcl_pkg.sv
rtl/core/gcl_alu.sv
rtl/core/gcd_lcm_unit.sv
verif/gcd_lcm_unit_tb.sv
